// ===== rtl/upc_pkg.sv =====
// Shared types, constants and codes for the UDP port redirect classifier.
package upc_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] ETH_HDR_LEN = 16'd14;
    localparam logic [15:0] IP_HDR_END_MIN = 16'd34;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;
    localparam logic [15:0] PORT_OFFSET = 16'd2;
    localparam logic [15:0] PROTO_POS = 16'd23;
    localparam logic [15:0] ETHERTYPE_HI_POS = 16'd12;
    localparam logic [15:0] ETHERTYPE_LO_POS = 16'd13;
    localparam logic [3:0] IHL_MIN = 4'd5;

    localparam logic OP_FRAME_BYTE = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_DROP = 2'd0,
        VERDICT_PASS = 2'd1,
        VERDICT_REDIRECT = 2'd2,
        VERDICT_ABORT = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_VERDICT = 2'd1,
        CMD_LOOKUP = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic operation;
        logic [7:0] frame_byte;
        logic frame_end;
        logic [4:0] entry_index;
        logic [15:0] entry_port;
        logic [31:0] entry_device;
        logic entry_valid;
    } req_word_t;

    typedef struct packed {
        verdict_t verdict;
        logic [31:0] target_device;
    } rsp_word_t;

    typedef struct packed {
        cmd_kind_t kind;
        verdict_t verdict;
        logic [15:0] port;
        logic [4:0] index;
        logic [31:0] device;
        logic valid;
    } cmd_t;

endpackage

// ===== rtl/udp_port_redirect_classifier.sv =====
// A frame's command is queued when its last byte is taken; its verdict then passes the queue and the result register.
// Throughput: one word per cycle unless the queue is full; a four-word command queue decouples parser and table.
// The route table does one parallel port match per cycle unless the output stalls and takes one entry write per cycle.
// Reset clears the parser state, the queue, the result valid bit and every table valid bit.
// Keys and devices of table entries are not reset; an entry is used only after it is written.
module udp_port_redirect_classifier #(
    parameter int TABLE_ENTRIES = upc_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  upc_pkg::req_word_t req_word,
    output logic rsp_valid,
    input  logic rsp_stall,
    output upc_pkg::rsp_word_t rsp_word
);
    import upc_pkg::*;

    logic cmd_push;
    logic cmd_pop;
    logic queue_full;
    logic queue_not_empty;
    cmd_t push_word;
    cmd_t head_word;

    upc_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_word(req_word),
        .queue_full(queue_full),
        .req_stall(req_stall),
        .cmd_push(cmd_push),
        .cmd_word(push_word)
    );

    upc_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(cmd_push),
        .push_word(push_word),
        .pop(cmd_pop),
        .full(queue_full),
        .not_empty(queue_not_empty),
        .head_word(head_word)
    );

    upc_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_ready(queue_not_empty),
        .cmd_word(head_word),
        .cmd_pop(cmd_pop),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_word(rsp_word)
    );

endmodule

// ===== rtl/upc_front.sv =====
// Frame parser that captures header fields, classifies each frame at its last byte and forwards table writes.
module upc_front (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  upc_pkg::req_word_t req_word,
    input  logic queue_full,
    output logic req_stall,
    output logic cmd_push,
    output upc_pkg::cmd_t cmd_word
);
    import upc_pkg::*;

    logic [15:0] count_reg, count_next, count_upd;
    logic [15:0] ether_type_reg, ether_type_next, ether_type_upd;
    logic [3:0] header_words_reg, header_words_next, header_words_upd;
    logic [7:0] ip_protocol_reg, ip_protocol_next, ip_protocol_upd;
    logic [15:0] dest_port_reg, dest_port_next, dest_port_upd;
    logic [15:0] port_at;
    logic [15:0] ip_end;
    logic accept;
    logic frame_byte_taken;
    verdict_t verdict;
    logic need_lookup;

    assign req_stall = queue_full;
    assign accept = req_valid && !queue_full;
    assign frame_byte_taken = accept && (req_word.operation == OP_FRAME_BYTE);

    always_comb
    begin
        port_at = ETH_HDR_LEN + {10'd0, header_words_reg, 2'b00} + PORT_OFFSET;
        ether_type_upd = ether_type_reg;
        header_words_upd = header_words_reg;
        ip_protocol_upd = ip_protocol_reg;
        dest_port_upd = dest_port_reg;
        if (count_reg == ETHERTYPE_HI_POS)
        begin
            ether_type_upd = {req_word.frame_byte, ether_type_reg[7:0]};
        end
        else if (count_reg == ETHERTYPE_LO_POS)
        begin
            ether_type_upd = {ether_type_reg[15:8], req_word.frame_byte};
        end
        else if (count_reg == ETH_HDR_LEN)
        begin
            header_words_upd = req_word.frame_byte[3:0];
        end
        else if (count_reg == PROTO_POS)
        begin
            ip_protocol_upd = req_word.frame_byte;
        end
        if (count_reg > ETH_HDR_LEN)
        begin
            if (count_reg == port_at)
            begin
                dest_port_upd = {req_word.frame_byte, dest_port_reg[7:0]};
            end
            else if (count_reg == port_at + 16'd1)
            begin
                dest_port_upd = {dest_port_reg[15:8], req_word.frame_byte};
            end
        end
        count_upd = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
    end

    always_comb
    begin
        ip_end = ETH_HDR_LEN + {10'd0, header_words_upd, 2'b00};
        need_lookup = 1'b0;
        verdict = VERDICT_DROP;
        if (count_upd < ETH_HDR_LEN)
        begin
            verdict = VERDICT_DROP;
        end
        else if (ether_type_upd != ETHERTYPE_IPV4)
        begin
            verdict = VERDICT_PASS;
        end
        else if (count_upd < IP_HDR_END_MIN)
        begin
            verdict = VERDICT_DROP;
        end
        else if (header_words_upd < IHL_MIN)
        begin
            verdict = VERDICT_DROP;
        end
        else if (ip_end > count_upd)
        begin
            verdict = VERDICT_DROP;
        end
        else if (ip_protocol_upd != PROTO_UDP)
        begin
            verdict = VERDICT_PASS;
        end
        else if (ip_end + UDP_HDR_LEN > count_upd)
        begin
            verdict = VERDICT_DROP;
        end
        else
        begin
            need_lookup = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ether_type_next = ether_type_reg;
        header_words_next = header_words_reg;
        ip_protocol_next = ip_protocol_reg;
        dest_port_next = dest_port_reg;
        if (frame_byte_taken)
        begin
            if (req_word.frame_end)
            begin
                count_next = '0;
                ether_type_next = '0;
                header_words_next = '0;
                ip_protocol_next = '0;
                dest_port_next = '0;
            end
            else
            begin
                count_next = count_upd;
                ether_type_next = ether_type_upd;
                header_words_next = header_words_upd;
                ip_protocol_next = ip_protocol_upd;
                dest_port_next = dest_port_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ether_type_reg <= '0;
            header_words_reg <= '0;
            ip_protocol_reg <= '0;
            dest_port_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ether_type_reg <= ether_type_next;
            header_words_reg <= header_words_next;
            ip_protocol_reg <= ip_protocol_next;
            dest_port_reg <= dest_port_next;
        end
    end

    always_comb
    begin
        cmd_push = 1'b0;
        cmd_word.kind = CMD_WRITE;
        cmd_word.verdict = verdict;
        cmd_word.port = dest_port_upd;
        cmd_word.index = req_word.entry_index;
        cmd_word.device = req_word.entry_device;
        cmd_word.valid = req_word.entry_valid;
        if (accept)
        begin
            if (req_word.operation == OP_TABLE_WRITE)
            begin
                cmd_push = 1'b1;
                cmd_word.kind = CMD_WRITE;
                cmd_word.port = req_word.entry_port;
            end
            else if (req_word.frame_end)
            begin
                cmd_push = 1'b1;
                cmd_word.kind = need_lookup ? CMD_LOOKUP : CMD_VERDICT;
            end
        end
    end

endmodule

// ===== rtl/upc_queue.sv =====
// Short command queue between the frame parser and the route table stage.
module upc_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  upc_pkg::cmd_t push_word,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output upc_pkg::cmd_t head_word
);
    import upc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_word = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/upc_back.sv =====
// Route table with parallel port match and the registered result stage.
module upc_back #(
    parameter int TABLE_ENTRIES = upc_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_ready,
    input  upc_pkg::cmd_t cmd_word,
    output logic cmd_pop,
    output logic rsp_valid,
    input  logic rsp_stall,
    output upc_pkg::rsp_word_t rsp_word
);
    import upc_pkg::*;

    logic [15:0] route_port_reg [TABLE_ENTRIES];
    logic [31:0] route_device_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] route_valid_reg, route_valid_next;
    logic [TABLE_ENTRIES-1:0] write_sel;
    logic hit;
    logic [31:0] hit_device;
    logic can_load;
    logic table_write;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_word_reg, rsp_word_next;

    assign can_load = !rsp_valid_reg || !rsp_stall;
    assign table_write = cmd_ready && (cmd_word.kind == CMD_WRITE);
    assign cmd_pop = cmd_ready && ((cmd_word.kind == CMD_WRITE) || can_load);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word = rsp_word_reg;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            write_sel[i] = table_write && (int'(cmd_word.index) == i);
        end
    end

    always_comb
    begin
        hit = 1'b0;
        hit_device = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (route_valid_reg[i] && (route_port_reg[i] == cmd_word.port))
            begin
                hit = 1'b1;
                hit_device = route_device_reg[i];
            end
        end
    end

    always_comb
    begin
        route_valid_next = route_valid_reg;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (write_sel[i])
            begin
                route_valid_next[i] = cmd_word.valid;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next = rsp_word_reg;
        if (cmd_pop)
        begin
            case (cmd_word.kind)
                CMD_VERDICT:
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next.verdict = cmd_word.verdict;
                    rsp_word_next.target_device = '0;
                end
                CMD_LOOKUP:
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next.verdict = hit ? VERDICT_REDIRECT : VERDICT_ABORT;
                    rsp_word_next.target_device = hit ? hit_device : 32'd0;
                end
                default:
                begin
                    rsp_word_next = rsp_word_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (write_sel[i])
            begin
                route_port_reg[i] <= cmd_word.port;
                route_device_reg[i] <= cmd_word.device;
            end
        end
        rsp_word_reg <= rsp_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            route_valid_reg <= route_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule
